// ===== hw/rtl/vsa_pkg.sv =====
// Shared types and codes for the voice slot allocator.
// Used by vsa_cell and voice_slot_allocator; depends on nothing.
package vsa_pkg;

  localparam int ACT_W   = 7;   // active_voices register
  localparam int SLOT_W  = 16;  // slot field of a handle
  localparam int GEN_W   = 16;  // generation field of a handle
  localparam int STAMP_W = 64;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_TRIGGER = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // Search token that walks the row of slot cells, one cell per cycle while the row advances.
  typedef struct packed {
    logic               valid;
    logic               idle_found;
    logic [SLOT_W-1:0]  idle_idx;
    logic [GEN_W-1:0]   idle_gen;
    logic               min_found;
    logic [SLOT_W-1:0]  min_idx;
    logic [STAMP_W-1:0] min_stamp;
    logic [GEN_W-1:0]   min_gen;
    logic               rel_hit;
  } token_t;

  // Operands of the word being searched, seen by every cell.
  typedef struct packed {
    logic [SLOT_W-1:0] rel_slot;  // slot plus one, from the handle
    logic [GEN_W-1:0]  rel_gen;
    logic [ACT_W-1:0]  active;
  } ctx_t;

  // Slot update broadcast at the end of a search.
  typedef struct packed {
    logic               en;
    logic               trigger;  // 1 stamp and bump, 0 mark idle
    logic [SLOT_W-1:0]  slot;
    logic [STAMP_W-1:0] stamp;
  } commit_t;

endpackage

// ===== hw/rtl/vsa_cell.sv =====
// One voice slot: idle flag, trigger stamp and generation, plus one stage
// of the search token pipeline. Depends on vsa_pkg.
module vsa_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             clear,
  input  vsa_pkg::ctx_t    ctx,
  input  vsa_pkg::commit_t commit,
  input  vsa_pkg::token_t  tok_in,
  output vsa_pkg::token_t  tok_out
);

  logic                        idle;
  logic [vsa_pkg::STAMP_W-1:0] stamp;
  logic [vsa_pkg::GEN_W-1:0]   gen;
  vsa_pkg::token_t             tok_next;
  logic                        in_range;
  logic                        hit;

  assign in_range = 32'(CELL_IDX) < 32'(ctx.active);
  assign hit      = commit.en && (commit.slot == vsa_pkg::SLOT_W'(CELL_IDX));

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && in_range) begin
      // first idle slot wins
      if (idle && !tok_in.idle_found) begin
        tok_next.idle_found = 1'b1;
        tok_next.idle_idx   = vsa_pkg::SLOT_W'(CELL_IDX);
        tok_next.idle_gen   = gen;
      end
      // strictly older only, so ties keep the lower slot
      if (!tok_in.min_found || (stamp < tok_in.min_stamp)) begin
        tok_next.min_found = 1'b1;
        tok_next.min_idx   = vsa_pkg::SLOT_W'(CELL_IDX);
        tok_next.min_stamp = stamp;
        tok_next.min_gen   = gen;
      end
      if ((ctx.rel_slot == vsa_pkg::SLOT_W'(CELL_IDX + 1)) && (ctx.rel_gen == gen)) begin
        tok_next.rel_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle    <= 1'b1;
      stamp   <= '0;
      gen     <= '0;
      tok_out <= '0;
    end else begin
      if (clear) begin
        idle  <= 1'b1;
        stamp <= '0;
        gen   <= '0;
      end else if (hit) begin
        if (commit.trigger) begin
          idle  <= 1'b0;
          stamp <= commit.stamp;
          gen   <= gen + 1'b1;
        end else begin
          idle <= 1'b1;
        end
      end
      if (advance) begin
        tok_out <= tok_next;
      end
    end
  end

endmodule

// ===== hw/rtl/voice_slot_allocator.sv =====
// Voice slot allocator top level: item capture, row of slot cells, result
// register and slot update broadcast. Depends on vsa_pkg and vsa_cell.
//
//   channel   direction  handshake            payload
//   in        in         in_valid/in_ready    op voice_id done_slot note_tag source_tag
//   out       out        out_valid/out_ready  action target_slot handle was_stolen
//                                             note_out source_out
//   cfg       in         cfg_we               cfg_wdata (active_voices)
//
// The search token walks the row of MAX_VOICES cells one cell per cycle, after
// the start register, and the result register follows the last cell. One word
// is in flight: busy clears on the edge that registers its result, and only
// then can the next word be accepted. A stalled output holds the token at the
// end of the row until the result register frees. Synchronous reset leaves all
// slots idle, stamps and generations zero, next stamp one, and active_voices
// zero.
module voice_slot_allocator #(
  parameter int MAX_VOICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] voice_id,
  input  logic [5:0]  done_slot,
  input  logic [15:0] note_tag,
  input  logic [15:0] source_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [5:0]  target_slot,
  output logic [31:0] handle,
  output logic        was_stolen,
  output logic [15:0] note_out,
  output logic [15:0] source_out
);

  logic                        busy;
  logic                        start;
  logic [vsa_pkg::ACT_W-1:0]   active;
  logic [vsa_pkg::STAMP_W-1:0] next_stamp;
  logic [1:0]                  item_op;
  logic [31:0]                 item_vid;
  logic [5:0]                  item_done;
  logic [15:0]                 item_note;
  logic [15:0]                 item_src;

  vsa_pkg::token_t             tok [MAX_VOICES+1];
  logic [MAX_VOICES-1:0]       tok_valid;
  vsa_pkg::token_t             end_tok;
  vsa_pkg::ctx_t               ctx;
  vsa_pkg::commit_t            commit;

  logic                        accept;
  logic                        advance;
  logic                        finish;
  logic                        do_trig;
  logic                        do_rel;
  logic                        do_fin;
  logic [vsa_pkg::SLOT_W-1:0]  tgt;
  logic [vsa_pkg::GEN_W-1:0]   tgt_gen;
  logic [vsa_pkg::SLOT_W-1:0]  rel_idx;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  assign ctx.rel_slot = item_vid[15:0];
  assign ctx.rel_gen  = item_vid[31:16];
  assign ctx.active   = active;

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = start;
  end

  for (genvar i = 0; i < MAX_VOICES; i++) begin : g_cell
    vsa_cell #(.CELL_IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .clear   (cfg_we),
      .ctx     (ctx),
      .commit  (commit),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
    assign tok_valid[i] = tok[i+1].valid;
  end

  assign end_tok = tok[MAX_VOICES];
  // hold the row while a finished word cannot enter the result register
  assign advance = !(end_tok.valid && out_valid && !out_ready);
  assign finish  = end_tok.valid && advance;

  assign do_trig = (item_op == vsa_pkg::OP_ACQUIRE) && (active != '0);
  assign do_rel  = (item_op == vsa_pkg::OP_RELEASE) && end_tok.rel_hit;
  assign do_fin  = (item_op == vsa_pkg::OP_FINISH) && (32'(item_done) < 32'(active));
  assign tgt     = end_tok.idle_found ? end_tok.idle_idx : end_tok.min_idx;
  assign tgt_gen = (end_tok.idle_found ? end_tok.idle_gen : end_tok.min_gen) + 1'b1;
  assign rel_idx = item_vid[15:0] - 16'd1;

  always_comb begin
    commit.en      = finish && (do_trig || do_fin);
    commit.trigger = do_trig;
    commit.slot    = do_trig ? tgt : vsa_pkg::SLOT_W'(item_done);
    commit.stamp   = next_stamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      start      <= 1'b0;
      active     <= '0;
      next_stamp <= 64'd1;
      out_valid  <= 1'b0;
    end else begin
      start <= accept;
      if (cfg_we) begin
        if (32'(cfg_wdata) > 32'(MAX_VOICES)) begin
          active <= vsa_pkg::ACT_W'(MAX_VOICES);
        end else begin
          active <= cfg_wdata;
        end
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish && do_trig) begin
        next_stamp <= next_stamp + 64'd1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op   <= op;
      item_vid  <= voice_id;
      item_done <= done_slot;
      item_note <= note_tag;
      item_src  <= source_tag;
    end
    if (finish) begin
      action      <= vsa_pkg::ACT_NONE;
      target_slot <= '0;
      handle      <= '0;
      was_stolen  <= 1'b0;
      note_out    <= '0;
      source_out  <= '0;
      if (do_trig) begin
        action      <= vsa_pkg::ACT_TRIGGER;
        target_slot <= tgt[5:0];
        handle      <= {tgt_gen, tgt + 16'd1};
        was_stolen  <= !end_tok.idle_found;
        note_out    <= item_note;
        source_out  <= item_src;
      end else if (do_rel) begin
        action      <= vsa_pkg::ACT_RELEASE;
        target_slot <= rel_idx[5:0];
      end
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= 1)
    else $error("more than one search token in the slot row");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted while a word is in flight");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("finished search did not load the result register");

  a_stamp_advance: assert property (@(posedge clk) disable iff (rst)
    (commit.en && commit.trigger) |=> (next_stamp == $past(next_stamp) + 64'd1))
    else $error("trigger did not advance the stamp");

endmodule
